// File: src/rfd_pkg.sv
// Shared types and constants for the radio frame header deframer.
// No dependencies; imported by every module under src.
package rfd_pkg;

  localparam int unsigned HeaderBytes = 7;
  localparam int unsigned CountW      = 8;

  localparam logic [7:0] SEQ_END_VALUE   = 8'hFF;
  localparam logic [7:0] MAX_LEN_DEFAULT = 8'd8;

  // result_kind codes
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // frame_class codes
  localparam logic [1:0] CLASS_BEGIN = 2'd0;
  localparam logic [1:0] CLASS_END   = 2'd1;
  localparam logic [1:0] CLASS_ACK   = 2'd2;
  localparam logic [1:0] CLASS_DATA  = 2'd3;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] to_addr;
    logic [15:0] from_addr;
    logic [7:0]  ack_id;
    logic [7:0]  seq_num;
    logic [7:0]  payload_len;
    logic [1:0]  frame_class;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic        length_error;
    logic        last;
  } result_t;

  function automatic logic [1:0] class_of(input logic [7:0] seq, input logic [7:0] len);
    logic [1:0] cls;
    if (len != 8'd0)                cls = CLASS_DATA;
    else if (seq == 8'd0)           cls = CLASS_BEGIN;
    else if (seq == SEQ_END_VALUE)  cls = CLASS_END;
    else                            cls = CLASS_ACK;
    return cls;
  endfunction

endpackage

// File: src/rfd_parser.sv
// Frame parser: phase, byte counter and header field registers.
// Builds at most one result word per consumed byte; depends on rfd_pkg.
module rfd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  logic [7:0]       max_len,
  output logic             emit,
  output rfd_pkg::result_t result
);
  import rfd_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [CountW-1:0] LastHdrPos = CountW'(HeaderBytes - 1);

  phase_t            phase, phase_next, phase_eff;
  logic [CountW-1:0] byte_count, byte_count_next, cnt_eff;
  logic [15:0]       dest_reg, dest_next, src_reg, src_next;
  logic [7:0]        ack_reg, ack_next, seq_reg, seq_next, len_reg, len_next;
  logic [CountW:0]   cnt_plus1;

  assign phase_eff = frame_start ? PH_HEADER : phase;
  assign cnt_eff   = frame_start ? '0 : byte_count;
  assign cnt_plus1 = {1'b0, cnt_eff} + 1'b1;

  always_comb begin
    phase_next      = phase_eff;
    byte_count_next = cnt_eff;
    dest_next       = dest_reg;
    src_next        = src_reg;
    ack_next        = ack_reg;
    seq_next        = seq_reg;
    len_next        = len_reg;
    emit            = 1'b0;
    result          = '0;
    unique case (phase_eff)
      PH_HEADER: begin
        case (cnt_eff)
          8'd0:    dest_next = {rx_byte, dest_reg[7:0]};
          8'd1:    dest_next = {dest_reg[15:8], rx_byte};
          8'd2:    src_next  = {rx_byte, src_reg[7:0]};
          8'd3:    src_next  = {src_reg[15:8], rx_byte};
          8'd4:    ack_next  = rx_byte;
          8'd5:    seq_next  = rx_byte;
          default: len_next  = rx_byte;
        endcase
        if (cnt_eff < LastHdrPos) begin
          byte_count_next = cnt_plus1[CountW-1:0];
        end else begin
          byte_count_next     = '0;
          emit                = 1'b1;
          result.result_kind  = KIND_HEADER;
          if (len_next > max_len) begin
            phase_next          = PH_IDLE;
            result.length_error = 1'b1;
            result.last         = 1'b1;
          end else if (len_next == 8'd0) begin
            phase_next  = PH_IDLE;
            result.last = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        emit                 = 1'b1;
        result.result_kind   = KIND_PAYLOAD;
        result.payload_byte  = rx_byte;
        result.payload_index = cnt_eff;
        if (cnt_plus1 >= {1'b0, len_reg}) begin
          result.last     = 1'b1;
          phase_next      = PH_IDLE;
          byte_count_next = '0;
        end else begin
          byte_count_next = cnt_plus1[CountW-1:0];
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    result.to_addr     = dest_next;
    result.from_addr   = src_next;
    result.ack_id      = ack_next;
    result.seq_num     = seq_next;
    result.payload_len = len_next;
    result.frame_class = class_of(seq_next, len_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_count <= '0;
      dest_reg   <= '0;
      src_reg    <= '0;
      ack_reg    <= '0;
      seq_reg    <= '0;
      len_reg    <= '0;
    end else if (step) begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      dest_reg   <= dest_next;
      src_reg    <= src_next;
      ack_reg    <= ack_next;
      seq_reg    <= seq_next;
      len_reg    <= len_next;
    end
  end

endmodule

// File: src/rfd_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on rfd_pkg for the result word layout.
module rfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  rfd_pkg::result_t load_data,
  input  logic             res_stall,
  output logic             res_valid,
  output logic             free,
  output rfd_pkg::result_t data
);
  import rfd_pkg::*;

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// File: src/radio_frame_header_deframer.sv
// Top level of the radio frame header deframer: input word register,
// config register, parser and result register. Depends on rfd_pkg,
// rfd_parser and rfd_out_reg.
//
// Usage:
//   Receive channel (rx_valid / rx_stall): one frame byte per word plus
//   frame_start, which restarts the parser on the first byte of a frame.
//   Result channel (res_valid / res_stall): zero or one result word per
//   byte. The seventh header byte yields a header word (fields, class,
//   length_error); each payload byte yields a payload word with its index.
//   last marks the final word of a frame. Bytes outside a frame and the
//   first six header bytes yield nothing.
//   Latency: an accepted byte waits in the input word register; its result is
//   loaded into the result register once that is free, visible from then on.
//   Throughput: one byte per cycle sustained while res_stall stays low; the
//   only per-byte loop is the parser state update.
//   Stall: while a result waits under res_stall, the input register still
//   takes one more word; rx_stall rises only when that word is also held.
//   Reset (rst, synchronous): parser idle, header fields cleared, both
//   channels empty, max_payload_len back to 8.
//   cfg_wr_en / cfg_wr_data write max_payload_len; write only when idle.
module radio_frame_header_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        result_kind,
  output logic [15:0] to_addr,
  output logic [15:0] from_addr,
  output logic [7:0]  ack_id,
  output logic [7:0]  seq_num,
  output logic [7:0]  payload_len,
  output logic [1:0]  frame_class,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  output logic        length_error,
  output logic        last
);
  import rfd_pkg::*;

  logic       max_len_load;
  logic [7:0] max_payload_len;

  // input word register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_start;
  logic       rx_take;

  // parser / result register handshake
  logic    step;
  logic    emit;
  logic    res_load;
  logic    out_free;
  result_t parsed;
  result_t res_data;

  assign max_len_load = cfg_wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= MAX_LEN_DEFAULT;
    end else if (max_len_load) begin
      max_payload_len <= cfg_wr_data;
    end
  end

  // Held word is consumed once the result register can take its result.
  assign step     = in_full && out_free;
  assign res_load = step && emit;
  assign rx_stall = in_full && !out_free;
  assign rx_take  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_take) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      in_byte  <= rx_byte;
      in_start <= frame_start;
    end
  end

  rfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (in_byte),
    .frame_start (in_start),
    .max_len     (max_payload_len),
    .emit        (emit),
    .result      (parsed)
  );

  rfd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .load_data (parsed),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .free      (out_free),
    .data      (res_data)
  );

  assign result_kind   = res_data.result_kind;
  assign to_addr       = res_data.to_addr;
  assign from_addr     = res_data.from_addr;
  assign ack_id        = res_data.ack_id;
  assign seq_num       = res_data.seq_num;
  assign payload_len   = res_data.payload_len;
  assign frame_class   = res_data.frame_class;
  assign payload_byte  = res_data.payload_byte;
  assign payload_index = res_data.payload_index;
  assign length_error  = res_data.length_error;
  assign last          = res_data.last;

  // stall toward the sender only with a word actually held
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> in_full)
    else $error("rx_stall raised with empty input register");

  // never overwrite a result the consumer has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!res_valid || !res_stall))
    else $error("result register overwritten while stalled");

  // length errors come only on header words, and always close the frame
  a_len_err_closes: assert property (@(posedge clk) disable iff (rst)
    (res_valid && length_error) |-> (last && result_kind == KIND_HEADER))
    else $error("length_error without last on a header word");

  // payload index stays inside the declared length
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (res_valid && result_kind == KIND_PAYLOAD) |-> (payload_index < payload_len))
    else $error("payload index beyond payload length");

endmodule

// File: bench/radio_frame_header_deframer_tb.sv
// Self-checking bench for radio_frame_header_deframer: a directed table of
// framed bytes, then random frames under varying max_payload_len settings.
// Depends on rfd_pkg and the RTL under src; reads no files.
`timescale 1ns / 1ps

module radio_frame_header_deframer_tb;
  import rfd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_PAYLOAD} parse_ph_t;

  // One row of the directed table: byte, frame_start flag, and optionally a
  // hand-written header word that replaces the predicted one.
  typedef struct packed {
    logic [7:0] b;
    logic       start;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam int DirRows      = 24;
  localparam int PhaseCnt     = 6;
  localparam int WatchLimit   = 2000;  // cycles with no word moving on either side
  localparam int SettleCycles = 4;     // input reg + parser + result reg, with margin

  localparam result_t NoWord = '0;
  localparam result_t HdrBegin = '{KIND_HEADER, 16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00,
                                   CLASS_BEGIN, 8'h00, 8'h00, 1'b0, 1'b1};
  localparam result_t HdrTooLong = '{KIND_HEADER, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'h09,
                                     CLASS_DATA, 8'h00, 8'h00, 1'b1, 1'b1};
  localparam result_t HdrEnd = '{KIND_HEADER, 16'hA55A, 16'h3CC3, 8'h01, 8'hFF, 8'h00,
                                 CLASS_END, 8'h00, 8'h00, 1'b0, 1'b1};

  // Directed part, with max_payload_len at its reset value of 8.
  dir_row_t dir_tab [DirRows] = '{
    '{8'hAA, 1'b0, 1'b0, NoWord},     // stray byte while idle: ignored
    // all-zero header: begin frame, empty payload closes at the header
    '{8'h00, 1'b1, 1'b0, NoWord}, '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord}, '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b0, NoWord}, '{8'h00, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b1, HdrBegin},
    // all-ones header with length 9 > 8: flagged, frame dropped
    '{8'hFF, 1'b1, 1'b0, NoWord}, '{8'hFF, 1'b0, 1'b0, NoWord},
    '{8'hFF, 1'b0, 1'b0, NoWord}, '{8'hFF, 1'b0, 1'b0, NoWord},
    '{8'hFF, 1'b0, 1'b0, NoWord}, '{8'hFF, 1'b0, 1'b0, NoWord},
    '{8'h09, 1'b0, 1'b1, HdrTooLong},
    '{8'h55, 1'b0, 1'b0, NoWord},     // payload of the dropped frame: ignored
    '{8'h12, 1'b1, 1'b0, NoWord},     // frame abandoned after one byte
    // restart: seq 255 with no payload is an end frame
    '{8'hA5, 1'b1, 1'b0, NoWord}, '{8'h5A, 1'b0, 1'b0, NoWord},
    '{8'h3C, 1'b0, 1'b0, NoWord}, '{8'hC3, 1'b0, 1'b0, NoWord},
    '{8'h01, 1'b0, 1'b0, NoWord}, '{8'hFF, 1'b0, 1'b0, NoWord},
    '{8'h00, 1'b0, 1'b1, HdrEnd}
  };

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = 8'h00;
  logic        rx_valid    = 1'b0;
  logic [7:0]  rx_byte     = 8'h00;
  logic        frame_start = 1'b0;
  logic        res_stall   = 1'b0;
  logic        rx_stall, res_valid;
  logic        result_kind, length_error, last;
  logic [15:0] to_addr, from_addr;
  logic [7:0]  ack_id, seq_num, payload_len, payload_byte, payload_index;
  logic [1:0]  frame_class;

  radio_frame_header_deframer dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .frame_start(frame_start),
    .res_valid(res_valid), .res_stall(res_stall),
    .result_kind(result_kind), .to_addr(to_addr), .from_addr(from_addr),
    .ack_id(ack_id), .seq_num(seq_num), .payload_len(payload_len),
    .frame_class(frame_class), .payload_byte(payload_byte),
    .payload_index(payload_index), .length_error(length_error), .last(last)
  );

  // Bench-side copy of the parser state and the length limit.
  parse_ph_t   pr_phase = PH_IDLE;
  logic [7:0]  pr_count = 8'd0;
  logic [15:0] pr_dest  = 16'd0;
  logic [15:0] pr_src   = 16'd0;
  logic [7:0]  pr_ack   = 8'd0;
  logic [7:0]  pr_seq   = 8'd0;
  logic [7:0]  pr_len   = 8'd0;
  logic [7:0]  pr_max   = MAX_LEN_DEFAULT;

  result_t pending_words [$];   // header/payload words still owed by the block
  int      mism        = 0;
  int      taken_bytes = 0;     // bytes the parser did not ignore
  bit      jitter      = 1'b0;  // random gaps and stalls enabled
  int      idle_cycles = 0;
  int      stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Advance the parser copy by one byte. took: the byte was not ignored;
  // made: a word is owed for it, returned in r.
  function automatic void parse_byte(input logic [7:0] b, input logic s,
                                     output bit took, output bit made, output result_t r);
    took = 1'b0;
    made = 1'b0;
    r    = '0;
    if (s) begin
      pr_phase = PH_HEADER;
      pr_count = 8'd0;
    end
    if (pr_phase == PH_HEADER) begin
      took = 1'b1;
      case (pr_count)
        8'd0: pr_dest[15:8] = b;   // addresses arrive high byte first
        8'd1: pr_dest[7:0]  = b;
        8'd2: pr_src[15:8]  = b;
        8'd3: pr_src[7:0]   = b;
        8'd4: pr_ack        = b;
        8'd5: pr_seq        = b;
        default: pr_len     = b;
      endcase
      if (pr_count != HeaderBytes - 1) begin
        pr_count++;
      end else begin
        // header complete: one header word, frame may close right here
        pr_count      = 8'd0;
        made          = 1'b1;
        r.result_kind = KIND_HEADER;
        if (pr_len > pr_max) begin
          r.length_error = 1'b1;
          r.last         = 1'b1;
          pr_phase       = PH_IDLE;
        end else if (pr_len == 8'd0) begin
          r.last   = 1'b1;
          pr_phase = PH_IDLE;
        end else begin
          pr_phase = PH_PAYLOAD;
        end
      end
    end else if (pr_phase == PH_PAYLOAD) begin
      took            = 1'b1;
      made            = 1'b1;
      r.result_kind   = KIND_PAYLOAD;
      r.payload_byte  = b;
      r.payload_index = pr_count;
      if (pr_count + 9'd1 >= pr_len) begin
        r.last   = 1'b1;
        pr_phase = PH_IDLE;
        pr_count = 8'd0;
      end else begin
        pr_count++;
      end
    end
    if (made) begin
      // every word repeats the header fields and class of its frame
      r.to_addr     = pr_dest;
      r.from_addr   = pr_src;
      r.ack_id      = pr_ack;
      r.seq_num     = pr_seq;
      r.payload_len = pr_len;
      if (pr_len == 8'd0 && pr_seq == 8'd0)               r.frame_class = CLASS_BEGIN;
      else if (pr_len == 8'd0 && pr_seq == SEQ_END_VALUE) r.frame_class = CLASS_END;
      else if (pr_len == 8'd0)                            r.frame_class = CLASS_ACK;
      else                                                r.frame_class = CLASS_DATA;
    end
  endfunction

  function automatic void check_field(input string nm, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", nm, want, got);
      mism++;
    end
  endfunction

  // Offer one byte and hold it until taken. On return we sit at the edge that
  // took it, so the caller must drive the next word or drop valid right away.
  task automatic send_word(input logic [7:0] b, input logic s, input bit typed,
                           input result_t want);
    bit      took, made;
    result_t r;
    if (jitter && $urandom_range(0, 7) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    rx_valid    <= 1'b1;
    rx_byte     <= b;
    frame_start <= s;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    parse_byte(b, s, took, made, r);
    if (took) taken_bytes++;
    if (made) pending_words.push_back(typed ? want : r);
  endtask

  // Stop sending, let every owed word arrive, then cover bytes still in flight
  // that owe nothing.
  task automatic wait_for_drain();
    rx_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [7:0] v);
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pr_max = v;
  endtask

  // One random frame. Mostly well formed; sometimes the header is cut short
  // or the payload is abandoned, so the next start restarts mid-frame.
  task automatic send_frame(input bit force_full);
    logic [7:0] hdr [7];
    int         cut, n_pay, pick;
    for (int i = 0; i < 5; i++) hdr[i] = 8'($urandom);
    pick = $urandom_range(0, 3);
    hdr[5] = (pick == 0) ? 8'h00 : (pick == 1) ? SEQ_END_VALUE : 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 2)      hdr[6] = 8'd0;
    else if (pick <= 6) hdr[6] = 8'($urandom_range(1, 12));
    else if (pick == 7) hdr[6] = 8'($urandom_range(13, 48));
    else if (pick == 8) hdr[6] = pr_max;                        // right at the limit
    else                hdr[6] = (pr_max == 8'hFF) ? 8'($urandom) : pr_max + 8'd1;
    if (force_full) hdr[6] = 8'hFF;                              // deepest payload index
    cut = 7;
    if (!force_full && $urandom_range(0, 14) == 0) cut = $urandom_range(1, 6);
    for (int i = 0; i < cut; i++) send_word(hdr[i], i == 0, 1'b0, NoWord);
    if (cut == 7) begin
      if (hdr[6] > pr_max) begin
        n_pay = $urandom_range(0, 3);   // trailing bytes of a dropped frame
      end else begin
        n_pay = hdr[6];
        if (!force_full && hdr[6] != 0 && $urandom_range(0, 11) == 0)
          n_pay = $urandom_range(0, hdr[6] - 1);
      end
      for (int i = 0; i < n_pay; i++) send_word(8'($urandom), 1'b0, 1'b0, NoWord);
    end
  endtask

  // Result side: check every word taken, and stall in random bursts.
  always @(posedge clk) begin
    result_t got, want;
    if (!rst && res_valid && !res_stall) begin
      got = '{result_kind, to_addr, from_addr, ack_id, seq_num, payload_len,
              frame_class, payload_byte, payload_index, length_error, last};
      if (pending_words.size() == 0) begin
        $error("result word with nothing owed: kind %0b dest 0x%0h", result_kind, to_addr);
        mism++;
      end else begin
        want = pending_words.pop_front();
        check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
        check_field("to_addr", want.to_addr, got.to_addr);
        check_field("from_addr", want.from_addr, got.from_addr);
        check_field("ack_id", 16'(want.ack_id), 16'(got.ack_id));
        check_field("seq_num", 16'(want.seq_num), 16'(got.seq_num));
        check_field("payload_len", 16'(want.payload_len), 16'(got.payload_len));
        check_field("frame_class", 16'(want.frame_class), 16'(got.frame_class));
        check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        check_field("payload_index", 16'(want.payload_index), 16'(got.payload_index));
        check_field("length_error", 16'(want.length_error), 16'(got.length_error));
        check_field("last", 16'(want.last), 16'(got.last));
      end
    end
    if (stall_left == 0 && jitter && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 11);
    if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Watchdog: any word moving on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("radio_frame_header_deframer_tb: done, errors");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases each with its own
  // max_payload_len. The last phase runs with no gaps or stalls.
  initial begin
    int unsigned phase_items [PhaseCnt];
    int unsigned goal;
    logic [7:0]  lim;
    int          pick;
    bit          paused;
    phase_items = '{100, 290, 110, 110, 110, 130};
    paused      = 1'b0;
    repeat (4) @(posedge clk);
    rst    <= 1'b0;
    jitter <= 1'b1;
    foreach (dir_tab[i])
      send_word(dir_tab[i].b, dir_tab[i].start, dir_tab[i].typed, dir_tab[i].want);
    for (int p = 0; p < PhaseCnt; p++) begin
      case (p)
        0:       lim = 8'h00;           // every nonempty payload is too long
        1:       lim = 8'hFF;           // nothing is too long
        3:       lim = 8'h01;
        5:       lim = MAX_LEN_DEFAULT;
        default: lim = 8'($urandom_range(2, 254));
      endcase
      write_max_len(lim);
      jitter <= (p != 2 && p != PhaseCnt - 1);
      goal = taken_bytes + phase_items[p];
      if (p == 1) send_frame(1'b1);     // one full 255-byte payload
      while (taken_bytes < goal) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          // noise: random bytes, an occasional start among them
          repeat ($urandom_range(1, 8))
            send_word(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NoWord);
        end else if (pick <= 2) begin
          repeat ($urandom_range(1, 3)) send_word(8'($urandom), 1'b0, 1'b0, NoWord);
        end else begin
          send_frame(1'b0);
        end
        // hold the sender once until the block has caught up completely
        if (p == 3 && !paused && taken_bytes >= goal - phase_items[p] / 2) begin
          wait_for_drain();
          paused = 1'b1;
        end
      end
    end
    wait_for_drain();
    if (mism == 0 && pending_words.size() == 0) begin
      $display("radio_frame_header_deframer_tb: done, clean");
    end else begin
      $display("radio_frame_header_deframer_tb: done, errors");
    end
    $finish;
  end

endmodule
